[src/assert_macros.svh]
// assertion helper macros for the websocket deframer
// used by the top level; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds whenever the block is out of reset
`define WSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/wsd_pkg.sv]
// types and constants shared by the websocket deframer
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_MASK      = 3'd1;
  localparam logic [2:0] ST_FRAG_CONTROL = 3'd2;
  localparam logic [2:0] ST_BAD_OPCODE   = 3'd3;
  localparam logic [2:0] ST_STRAY_CONT   = 3'd4;
  localparam logic [2:0] ST_DISCARD      = 3'd5;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [2:0] HDR_CNT_16    = 3'd1;
  localparam logic [2:0] HDR_CNT_64    = 3'd7;
  localparam logic [2:0] HDR_CNT_MASK  = 3'd3;

  // one input item as seen by the parser
  typedef struct packed {
    logic       step;
    logic       restart;
    logic [7:0] stream_byte;
  } wsd_item_t;

  // one result item, valid says whether the item produced it
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] msg_opcode;
    logic       frame_end;
    logic       message_end;
    logic [2:0] status;
  } wsd_res_t;

endpackage

[src/wsd_ifs.sv]
// valid/ready channel interfaces for the websocket deframer
// no dependencies
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       restart;

  modport source (output valid, output stream_byte, output restart, input ready);
  modport sink (input valid, input stream_byte, input restart, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic [3:0] msg_opcode;
  logic       frame_end;
  logic       message_end;
  logic [2:0] status;

  modport source (output valid, output data_byte, output has_data, output msg_opcode,
                  output frame_end, output message_end, output status, input ready);
  modport sink (input valid, input data_byte, input has_data, input msg_opcode,
                input frame_end, input message_end, input status, output ready);
endinterface

[src/wsd_parser.sv]
// frame header parser and payload unmasker, one byte per step
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  wsd_pkg::wsd_item_t item,
  output wsd_pkg::wsd_res_t  res
);
  import wsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  frame_op_r, frame_op_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;
  logic [3:0]  frag_op_r, frag_op_nxt;
  logic        frag_open_r, frag_open_nxt;
  logic        halted_r, halted_nxt;

  logic [7:0]  b;
  logic [3:0]  op;
  logic [6:0]  len_code;
  logic        op_known;
  logic [63:0] rem_dec;
  logic        rem_last;
  logic [7:0]  key_byte;

  assign b        = item.stream_byte;
  assign op       = b[3:0];
  assign len_code = b[6:0];
  assign op_known = op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
  assign rem_dec  = rem_r - 64'd1;
  assign rem_last = (rem_dec == '0);

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    fin_nxt       = fin_r;
    frame_op_nxt  = frame_op_r;
    rem_nxt       = rem_r;
    key_nxt       = key_r;
    key_idx_nxt   = key_idx_r;
    frag_op_nxt   = frag_op_r;
    frag_open_nxt = frag_open_r;
    halted_nxt    = halted_r;
    if (item.step) begin
      if (item.restart) begin
        phase_nxt     = PH_HDR0;
        hdr_cnt_nxt   = '0;
        fin_nxt       = 1'b0;
        frame_op_nxt  = '0;
        rem_nxt       = '0;
        key_nxt       = '0;
        key_idx_nxt   = '0;
        frag_op_nxt   = '0;
        frag_open_nxt = 1'b0;
        halted_nxt    = 1'b0;
      end else if (!halted_r) begin
        case (phase_r)
          PH_HDR0: begin
            fin_nxt = b[7];
            if (!op_known) begin
              halted_nxt = 1'b1;
            end else if (op[3]) begin
              if (!b[7]) begin
                halted_nxt = 1'b1;
              end else begin
                frame_op_nxt = op;
                phase_nxt    = PH_HDR1;
              end
            end else if (op == OP_CONT) begin
              if (!frag_open_r) begin
                halted_nxt = 1'b1;
              end else begin
                frame_op_nxt = frag_op_r;
                if (b[7]) begin
                  frag_open_nxt = 1'b0;
                end
                phase_nxt = PH_HDR1;
              end
            end else begin
              frame_op_nxt  = op;
              frag_op_nxt   = op;
              frag_open_nxt = !b[7];
              phase_nxt     = PH_HDR1;
            end
          end
          PH_HDR1: begin
            if (!b[7]) begin
              halted_nxt = 1'b1;
            end else begin
              if (len_code <= LEN_MAX_SHORT) begin
                rem_nxt     = {57'd0, len_code};
                phase_nxt   = PH_MASK;
                hdr_cnt_nxt = HDR_CNT_MASK;
              end else begin
                rem_nxt     = '0;
                phase_nxt   = PH_EXTLEN;
                hdr_cnt_nxt = (len_code == LEN_CODE_16) ? HDR_CNT_16 : HDR_CNT_64;
              end
            end
          end
          PH_EXTLEN: begin
            rem_nxt = {rem_r[55:0], b};
            if (hdr_cnt_r == '0) begin
              phase_nxt   = PH_MASK;
              hdr_cnt_nxt = HDR_CNT_MASK;
            end else begin
              hdr_cnt_nxt = hdr_cnt_r - 3'd1;
            end
          end
          PH_MASK: begin
            key_nxt = {key_r[23:0], b};
            if (hdr_cnt_r != '0) begin
              hdr_cnt_nxt = hdr_cnt_r - 3'd1;
            end else begin
              key_idx_nxt = '0;
              phase_nxt   = (rem_r == '0) ? PH_HDR0 : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            key_idx_nxt = key_idx_r + 2'd1;
            rem_nxt     = rem_dec;
            if (rem_last) begin
              phase_nxt = PH_HDR0;
            end
          end
          default: begin
            phase_nxt = PH_HDR0;
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    res = '0;
    if (item.step && !item.restart && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          res.msg_opcode = op;
          if (!op_known) begin
            res.valid  = 1'b1;
            res.status = ST_BAD_OPCODE;
          end else if (op[3]) begin
            if (!b[7]) begin
              res.valid  = 1'b1;
              res.status = ST_FRAG_CONTROL;
            end
          end else if (op == OP_CONT) begin
            if (!frag_open_r) begin
              res.valid  = 1'b1;
              res.status = ST_STRAY_CONT;
            end
          end else if (frag_open_r) begin
            res.valid  = 1'b1;
            res.status = ST_DISCARD;
          end
        end
        PH_HDR1: begin
          if (!b[7]) begin
            res.valid      = 1'b1;
            res.msg_opcode = frame_op_r;
            res.status     = ST_NO_MASK;
          end
        end
        PH_MASK: begin
          if (hdr_cnt_r == '0 && rem_r == '0) begin
            res.valid       = 1'b1;
            res.msg_opcode  = frame_op_r;
            res.frame_end   = 1'b1;
            res.message_end = fin_r;
          end
        end
        PH_PAYLOAD: begin
          res.valid       = 1'b1;
          res.data_byte   = b ^ key_byte;
          res.has_data    = 1'b1;
          res.msg_opcode  = frame_op_r;
          res.frame_end   = rem_last;
          res.message_end = rem_last & fin_r;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      hdr_cnt_r   <= '0;
      fin_r       <= 1'b0;
      frame_op_r  <= '0;
      rem_r       <= '0;
      key_r       <= '0;
      key_idx_r   <= '0;
      frag_op_r   <= '0;
      frag_open_r <= 1'b0;
      halted_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      fin_r       <= fin_nxt;
      frame_op_r  <= frame_op_nxt;
      rem_r       <= rem_nxt;
      key_r       <= key_nxt;
      key_idx_r   <= key_idx_nxt;
      frag_op_r   <= frag_op_nxt;
      frag_open_r <= frag_open_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

[src/websocket_frame_deframer_core.sv]
// datapath: an accepted byte is held in the input reg, then its result is captured in the result reg
// throughput: one byte per cycle while out_ch is not stalled; the input reg advances whenever the result reg
// is free or taken in the same cycle, so back-to-back items flow without gaps
// reset: synchronous active-low rst_n clears all parser state and both valid flags;
// a restart item clears the parser state in order with the stream
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer_core (
  input logic       clk,
  input logic       rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);
  import wsd_pkg::*;

  logic       stage_valid_r;
  logic       stage_restart_r;
  logic [7:0] stage_byte_r;
  logic       stage_go;
  logic       out_valid_r;
  wsd_res_t   out_r;
  wsd_item_t  item;
  wsd_res_t   res;

  assign stage_go    = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stage_valid_r || stage_go;

  assign item.step        = stage_go;
  assign item.restart     = stage_restart_r;
  assign item.stream_byte = stage_byte_r;

  wsd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stage_byte_r    <= in_ch.stream_byte;
      stage_restart_r <= in_ch.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go) begin
      out_valid_r <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_byte   = out_r.data_byte;
  assign out_ch.has_data    = out_r.has_data;
  assign out_ch.msg_opcode  = out_r.msg_opcode;
  assign out_ch.frame_end   = out_r.frame_end;
  assign out_ch.message_end = out_r.message_end;
  assign out_ch.status      = out_r.status;

  `WSD_ASSERT_ALWAYS(a_status_clean, !out_valid_r || out_r.status == ST_OK || (!out_r.has_data && !out_r.frame_end && !out_r.message_end), "status item carries data or end marks")
  `WSD_ASSERT_ALWAYS(a_mend_in_fend, !out_valid_r || !out_r.message_end || out_r.frame_end, "message end without frame end")
  `WSD_ASSERT_NEXT(a_stage_hold, stage_valid_r && !stage_go, stage_valid_r && $stable(stage_byte_r) && $stable(stage_restart_r), "stalled input reg changed")
  `WSD_ASSERT_NEXT(a_no_overwrite, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_r), "pending result overwritten")

endmodule

[verif/websocket_frame_deframer_core_checker.sv]
// result checker for the websocket frame deframer: predicts results from accepted items
// depends on wsd_pkg for phases, opcodes, status codes and length constants
`timescale 1ns / 1ps

module wsd_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       in_restart,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_data_byte,
  input  logic       out_has_data,
  input  logic [3:0] out_msg_opcode,
  input  logic       out_frame_end,
  input  logic       out_message_end,
  input  logic [2:0] out_status,
  output int         failures,
  output int         pending
);
  import wsd_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] msg_opcode;
    logic       frame_end;
    logic       message_end;
    logic [2:0] status;
  } frame_result_t;

  frame_result_t expected_results[$];

  phase_t      phase;
  logic [2:0]  hdr_left;
  logic        fin;
  logic [3:0]  frame_op;
  logic [63:0] remaining;
  logic [31:0] key;
  logic [1:0]  key_idx;
  logic [3:0]  frag_op;
  logic        frag_open;
  logic        halted;

  task automatic clear_parser();
    phase     = PH_HDR0;
    hdr_left  = '0;
    fin       = 1'b0;
    frame_op  = OP_CONT;
    remaining = '0;
    key       = '0;
    key_idx   = '0;
    frag_op   = OP_CONT;
    frag_open = 1'b0;
    halted    = 1'b0;
  endtask

  task automatic push_result(input logic [7:0] data, input logic has, input logic [3:0] op,
                             input logic fend, input logic mend, input logic [2:0] st);
    frame_result_t r;
    r.data_byte   = data;
    r.has_data    = has;
    r.msg_opcode  = op;
    r.frame_end   = fend;
    r.message_end = mend;
    r.status      = st;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic halt_with(input logic [3:0] op, input logic [2:0] st);
    halted = 1'b1;
    push_result(8'h00, 1'b0, op, 1'b0, 1'b0, st);
  endtask

  // advance the deframer by one accepted item
  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    logic [3:0] op;
    logic [6:0] code;
    logic [7:0] kb;
    logic       warn;
    logic       fend;
    if (rs) begin
      clear_parser();
    end else if (!halted) begin
      case (phase)
        PH_HDR0: begin
          fin = b[7];
          op  = b[3:0];
          if (op != OP_CONT && op != OP_TEXT && op != OP_BINARY && op != OP_CLOSE &&
              op != OP_PING && op != OP_PONG) begin
            halt_with(op, ST_BAD_OPCODE);
          end else if (op[3]) begin
            if (!fin) begin
              halt_with(op, ST_FRAG_CONTROL);
            end else begin
              frame_op = op;
              phase    = PH_HDR1;
            end
          end else if (op == OP_CONT) begin
            if (!frag_open) begin
              halt_with(OP_CONT, ST_STRAY_CONT);
            end else begin
              frame_op = frag_op;
              if (fin) frag_open = 1'b0;
              phase = PH_HDR1;
            end
          end else begin
            warn      = frag_open;
            frame_op  = op;
            frag_op   = op;
            frag_open = !fin;
            phase     = PH_HDR1;
            if (warn) push_result(8'h00, 1'b0, op, 1'b0, 1'b0, ST_DISCARD);
          end
        end
        PH_HDR1: begin
          if (!b[7]) begin
            halt_with(frame_op, ST_NO_MASK);
          end else begin
            code      = b[6:0];
            remaining = '0;
            if (code <= LEN_MAX_SHORT) begin
              remaining = 64'(code);
              phase     = PH_MASK;
              hdr_left  = HDR_CNT_MASK;
            end else begin
              phase    = PH_EXTLEN;
              hdr_left = (code == LEN_CODE_16) ? HDR_CNT_16 : HDR_CNT_64;
            end
          end
        end
        PH_EXTLEN: begin
          remaining = {remaining[55:0], b};
          if (hdr_left == 0) begin
            phase    = PH_MASK;
            hdr_left = HDR_CNT_MASK;
          end else begin
            hdr_left = hdr_left - 1'b1;
          end
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (hdr_left != 0) begin
            hdr_left = hdr_left - 1'b1;
          end else begin
            key_idx = '0;
            if (remaining == 0) begin
              phase = PH_HDR0;
              push_result(8'h00, 1'b0, frame_op, 1'b1, fin, ST_OK);
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          kb        = key[8 * (3 - key_idx) +: 8];
          key_idx   = key_idx + 1'b1;
          remaining = remaining - 1'b1;
          fend      = (remaining == 0);
          if (fend) phase = PH_HDR0;
          push_result(b ^ kb, 1'b1, frame_op, fend, fend & fin, ST_OK);
        end
        default: phase = PH_HDR0;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      failures = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: data_byte %0h has_data %0b msg_opcode %0h status %0d",
                 out_data_byte, out_has_data, out_msg_opcode, out_status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("has_data", 8'(want.has_data), 8'(out_has_data));
          check_field("msg_opcode", 8'(want.msg_opcode), 8'(out_msg_opcode));
          check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
          check_field("message_end", 8'(want.message_end), 8'(out_message_end));
          check_field("status", 8'(want.status), 8'(out_status));
        end
      end
      if (in_valid && in_ready) deframe_byte(in_stream_byte, in_restart);
    end
    pending = expected_results.size();
  end

endmodule

[verif/websocket_frame_deframer_core_test.sv]
// testbench top for websocket_frame_deframer_core: frame stream stimulus and verdict
// depends on wsd_pkg, wsd_ifs, the deframer core and wsd_frame_checker
`timescale 1ns / 1ps

module websocket_frame_deframer_core_test;
  import wsd_pkg::*;

  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;

  localparam logic [6:0] LEN_CODE_64     = 7'd127;
  localparam logic [3:0] OP_RESERVED_TOP = 4'hF;
  localparam int         RANDOM_ITEMS    = 1800;
  localparam int         CALM_ITEMS      = 1500;

  logic clk = 1'b0;
  logic rst_n;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   item_count = 0;
  int   failures;
  int   pending;

  wsd_in_if  in_ch();
  wsd_out_if out_ch();

  websocket_frame_deframer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wsd_frame_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_stream_byte  (in_ch.stream_byte),
    .in_restart      (in_ch.restart),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data_byte   (out_ch.data_byte),
    .out_has_data    (out_ch.has_data),
    .out_msg_opcode  (out_ch.msg_opcode),
    .out_frame_end   (out_ch.frame_end),
    .out_message_end (out_ch.message_end),
    .out_status      (out_ch.status),
    .failures        (failures),
    .pending         (pending)
  );

  always #2 clk = ~clk;

  // live is clear for bytes the block ignores while halted
  task automatic drive_item(input logic [7:0] b, input logic rs, input bit live);
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= b;
    in_ch.restart     <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (live) item_count++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_item(b, 1'b0, 1'b1);
  endtask

  task automatic send_restart();
    drive_item(8'($urandom), 1'b1, 1'b1);
  endtask

  function automatic logic [3:0] data_op();
    return $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
  endfunction

  function automatic logic [3:0] control_op();
    case ($urandom_range(0, 2))
      0:       return OP_CLOSE;
      1:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  function automatic bit known_op(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
           op == OP_PING || op == OP_PONG;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  task automatic pick_len(output len_form_t form, output logic [63:0] len);
    int r;
    r    = $urandom_range(0, 99);
    form = LEN_SHORT;
    if (r < 65) begin
      len = 64'($urandom_range(0, 12));
    end else if (r < 68) begin
      len = 64'(LEN_MAX_SHORT);
    end else if (r < 76) begin
      len = 64'($urandom_range(13, 124));
    end else if (r < 90) begin
      form = LEN_16;
      len  = 64'($urandom_range(0, 140));
    end else begin
      form = LEN_64;
      len  = 64'($urandom_range(0, 30));
    end
  endtask

  task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                             input len_form_t form, input logic [63:0] len);
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_16: begin
        send_byte({masked, LEN_CODE_16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input len_form_t form,
                            input logic [63:0] len, input int body);
    int r;
    r = $urandom_range(0, 9);
    send_header(fin, op, 1'b1, form, len);
    repeat (4) send_byte(r == 0 ? 8'h00 : r == 1 ? 8'hff : 8'($urandom));
    repeat (body) send_byte(8'($urandom));
  endtask

  task automatic send_data_frame(input logic fin, input logic [3:0] op);
    len_form_t   form;
    logic [63:0] len;
    pick_len(form, len);
    send_frame(fin, op, form, len, int'(len));
  endtask

  task automatic maybe_control();
    if ($urandom_range(0, 3) == 0) send_data_frame(1'b1, control_op());
  endtask

  task automatic run_fragmented();
    int n;
    n = $urandom_range(1, 3);
    send_data_frame(1'b0, data_op());
    for (int i = 0; i < n; i++) begin
      maybe_control();
      send_data_frame(i == n - 1, OP_CONT);
    end
  endtask

  // long frame cut short by a restart
  task automatic run_truncated();
    logic [63:0] len;
    if ($urandom_range(0, 1)) begin
      len     = {$urandom, $urandom};
      len[40] = 1'b1;
      if ($urandom_range(0, 3) == 0) len = '1;
      send_frame(1'b1, data_op(), LEN_64, len, $urandom_range(0, 6));
    end else begin
      len = $urandom_range(0, 1) ? 64'hffff : 64'($urandom_range(1000, 65534));
      send_frame(1'b1, data_op(), LEN_16, len, $urandom_range(0, 6));
    end
    send_restart();
  endtask

  task automatic run_fatal();
    logic [3:0] op;
    case ($urandom_range(0, 3))
      0: begin
        op = 4'($urandom_range(0, 15));
        while (known_op(op)) op = 4'($urandom_range(0, 15));
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op});
      end
      1: send_byte({1'b0, 3'($urandom_range(0, 7)), control_op()});
      2: send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), OP_CONT});
      default: begin
        if ($urandom_range(0, 1)) begin
          send_data_frame(1'b0, data_op());
          op = OP_CONT;
        end else begin
          op = $urandom_range(0, 1) ? data_op() : control_op();
        end
        send_header(1'b1, op, 1'b0, LEN_SHORT, 64'($urandom_range(0, 127)));
      end
    endcase
    repeat ($urandom_range(0, 3)) drive_item(8'($urandom), 1'b0, 1'b0);
    send_restart();
  endtask

  // result side backpressure
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int pick;
    int next_knob;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.stream_byte <= 8'h00;
    in_ch.restart     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // stray continuation, then a byte ignored while halted
    send_byte({1'b1, 3'b000, OP_CONT});
    send_byte(8'hff);
    send_restart();
    send_byte({1'b1, 3'b000, OP_RESERVED_TOP});
    send_restart();
    // control frame without fin
    send_byte({1'b0, 3'b000, OP_PONG});
    send_restart();
    // mask bit clear
    send_byte({1'b1, 3'b000, OP_BINARY});
    send_byte({1'b0, 7'd0});
    send_restart();
    // empty first fragment with reserved bits set
    send_byte({1'b0, 3'b111, OP_TEXT});
    send_byte({1'b1, 7'd0});
    repeat (4) send_byte(8'hff);
    // ping between fragments
    send_byte({1'b1, 3'b000, OP_PING});
    send_byte({1'b1, 7'd1});
    send_byte(8'h5a);
    send_byte(8'ha5);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    // new data frame while the fragmented message is open
    send_byte({1'b1, 3'b000, OP_BINARY});

    send_restart();
    item_count = 0;
    next_knob  = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (item_count >= CALM_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (item_count >= next_knob) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
        next_knob += 200;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        maybe_control();
        send_data_frame(1'b1, data_op());
      end else if (pick < 60) begin
        run_fragmented();
      end else if (pick < 70) begin
        send_data_frame(1'b1, control_op());
      end else if (pick < 76) begin
        send_data_frame(1'b0, data_op());
        maybe_control();
        send_data_frame(1'b1, data_op());
      end else if (pick < 82) begin
        run_truncated();
      end else if (pick < 93) begin
        run_fatal();
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        send_restart();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/wsd_pkg.sv
src/wsd_ifs.sv
src/wsd_parser.sv
src/websocket_frame_deframer_core.sv
verif/websocket_frame_deframer_core_checker.sv
verif/websocket_frame_deframer_core_test.sv
